[hdl/los_guidance_angles_unit_macros.svh]
// Assertion macros for the line-of-sight guidance angle unit
`ifndef LOS_GUIDANCE_ANGLES_UNIT_MACROS_SVH
`define LOS_GUIDANCE_ANGLES_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define LGA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define LGA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/lga_pkg.sv]
// Types, constants and CORDIC helpers for the line-of-sight guidance angle unit
package lga_pkg;

    localparam int IW            = 32;
    localparam int DW            = 33;
    localparam int CW            = 31;
    localparam int W             = 56;
    localparam int AW            = 36;
    localparam int OW            = 16;
    localparam int NUM_IN        = 9;
    localparam int STEPS_DEFAULT = 16;

    localparam logic signed [AW-1:0] PI_Q30    = 36'sd3373259426;
    localparam logic [CW-1:0]        GAIN_Q29  = 31'd884097682;
    localparam logic [CW-1:0]        GAIN2_Q29 = 31'd1455896918;
    localparam logic [CW-1:0]        LOOKAHEAD_RESET = 31'd327680;
    localparam logic signed [AW:0]   ROUND_HALF = 37'sd131072;
    localparam logic signed [AW:0]   OUT_MAX = 37'sd32767;
    localparam logic signed [AW:0]   OUT_MIN = -37'sd32768;

    typedef enum logic {
        REG_LOOKAHEAD_H = 1'b0,
        REG_LOOKAHEAD_V = 1'b1
    } reg_index_t;

    typedef logic signed [W-1:0]  vec_t;
    typedef logic signed [AW-1:0] ang_t;
    typedef logic signed [DW-1:0] diff_t;

    typedef struct packed {
        vec_t x;
        vec_t y;
        vec_t cx;
        vec_t cy;
        ang_t ang;
        logic act;
    } cordic_t;

    function automatic ang_t atan_tab(input logic [4:0] k);
        ang_t r;
        case (k)
            5'd0:  r = 36'sd843314857;
            5'd1:  r = 36'sd497837829;
            5'd2:  r = 36'sd263043837;
            5'd3:  r = 36'sd133525159;
            5'd4:  r = 36'sd67021687;
            5'd5:  r = 36'sd33543516;
            5'd6:  r = 36'sd16775851;
            5'd7:  r = 36'sd8388437;
            5'd8:  r = 36'sd4194283;
            5'd9:  r = 36'sd2097149;
            5'd10: r = 36'sd1048576;
            5'd11: r = 36'sd524288;
            5'd12: r = 36'sd262144;
            5'd13: r = 36'sd131072;
            5'd14: r = 36'sd65536;
            5'd15: r = 36'sd32768;
            5'd16: r = 36'sd16384;
            5'd17: r = 36'sd8192;
            5'd18: r = 36'sd4096;
            5'd19: r = 36'sd2048;
            5'd20: r = 36'sd1024;
            5'd21: r = 36'sd512;
            5'd22: r = 36'sd256;
            5'd23: r = 36'sd128;
            5'd24: r = 36'sd64;
            5'd25: r = 36'sd32;
            5'd26: r = 36'sd16;
            5'd27: r = 36'sd8;
            5'd28: r = 36'sd4;
            5'd29: r = 36'sd2;
            5'd30: r = 36'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic vec_t widen16(input diff_t v);
        vec_t e;
        e = {{(W-DW){v[DW-1]}}, v};
        return e <<< 16;
    endfunction

    function automatic vec_t gscale(input diff_t v, input logic [CW-1:0] c);
        logic signed [DW+CW:0] p;
        p = v * $signed({1'b0, c});
        return W'(p >>> 13);
    endfunction

    function automatic cordic_t cordic_setup(input vec_t x, input vec_t y,
                                             input vec_t cx, input vec_t cy);
        cordic_t r;
        r.act = (x != '0) || (y != '0);
        r.x   = x;
        r.y   = y;
        r.cx  = cx;
        r.cy  = cy;
        r.ang = '0;
        if (r.act && x[W-1])
        begin
            r.x   = -x;
            r.y   = -y;
            r.cx  = -cx;
            r.cy  = -cy;
            r.ang = y[W-1] ? -PI_Q30 : PI_Q30;
        end
        return r;
    endfunction

    function automatic cordic_t cordic_step(input cordic_t s, input logic [4:0] k);
        cordic_t r;
        vec_t xs;
        vec_t ys;
        vec_t cxs;
        vec_t cys;
        xs  = s.x >>> k;
        ys  = s.y >>> k;
        cxs = s.cx >>> k;
        cys = s.cy >>> k;
        r   = s;
        if (s.act)
        begin
            if (!s.y[W-1])
            begin
                r.x   = s.x + ys;
                r.y   = s.y - xs;
                r.cx  = s.cx + cys;
                r.cy  = s.cy - cxs;
                r.ang = s.ang + atan_tab(k);
            end
            else
            begin
                r.x   = s.x - ys;
                r.y   = s.y + xs;
                r.cx  = s.cx - cys;
                r.cy  = s.cy + cxs;
                r.ang = s.ang - atan_tab(k);
            end
        end
        return r;
    endfunction

    function automatic logic [OW-1:0] to_out(input logic signed [AW:0] a);
        logic signed [AW:0] r;
        r = (a + ROUND_HALF) >>> 18;
        if (r > OUT_MAX)
            r = OUT_MAX;
        else if (r < OUT_MIN)
            r = OUT_MIN;
        return r[OW-1:0];
    endfunction

endpackage

[hdl/los_guidance_angles_unit.sv]
// Line-of-sight guidance angle unit: waypoints and position in, yaw and pitch out
// Takes one word per cycle while not stalled and returns one word per word, in
// order. The path heading, the path pitch and the two lookahead arctangents each
// run through a chain of CORDIC_STEPS registered vectoring stages (the lookahead
// pair side by side). A result waiting at the output stalls the pipeline only once
// the last stage also holds a word; bubbles ahead of it keep filling.
`include "los_guidance_angles_unit_macros.svh"

module los_guidance_angles_unit
    import lga_pkg::*;
#(
    parameter int CORDIC_STEPS = STEPS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // prev_x, prev_y, prev_z, next_x, next_y, next_z, pos_x, pos_y, pos_z
    input  logic [NUM_IN*IW-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // yaw_cmd, pitch_cmd
    output logic [2*OW-1:0]       m_tdata,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  logic [CW-1:0]         cfg_data
);

    localparam int N = CORDIC_STEPS;

    typedef struct packed {
        diff_t dx;
        diff_t dy;
        diff_t dz;
        diff_t ex;
        diff_t ey;
        diff_t ez;
    } diff_set_t;

    typedef struct packed {
        diff_t dx;
        diff_t dy;
        diff_t ex;
        diff_t ey;
        vec_t  gex;
        vec_t  gey;
        vec_t  gez;
        vec_t  gdz;
        vec_t  gez2;
        logic  flat;
        logic  zero;
    } scale_t;

    typedef struct packed {
        cordic_t c;
        vec_t    gdz;
        vec_t    gez;
        vec_t    gez2;
        logic    zero;
    } p1_t;

    typedef struct packed {
        cordic_t c;
        ang_t    heading;
        vec_t    yk;
    } p2_t;

    typedef struct packed {
        cordic_t h;
        cordic_t v;
        ang_t    heading;
        ang_t    pitch;
    } p3_t;

    logic [CW-1:0] cfg_h_reg;
    logic [CW-1:0] cfg_v_reg;
    vec_t          lah_reg;
    vec_t          lav_reg;

    diff_set_t     diff_reg, diff_next;
    logic          v1_reg;
    scale_t        scale_reg, scale_next;
    logic          v2_reg;
    p1_t           p1_reg [0:N];
    p1_t           p1_next [0:N];
    logic          v_p1_reg [0:N];
    p2_t           p2_reg [0:N];
    p2_t           p2_next [0:N];
    logic          v_p2_reg [0:N];
    p3_t           p3_reg [0:N];
    p3_t           p3_next [0:N];
    logic          v_p3_reg [0:N];

    logic              m_tvalid_reg, m_tvalid_next;
    logic [2*OW-1:0]   m_tdata_reg, m_tdata_next;
    logic              adv;

    assign adv      = !(v_p3_reg[N] && m_tvalid_reg && !m_tready);
    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tvalid_next = (adv && v_p3_reg[N]) || (m_tvalid_reg && !m_tready);

    function automatic diff_t sub33(input logic [IW-1:0] a, input logic [IW-1:0] b);
        return $signed({a[IW-1], a}) - $signed({b[IW-1], b});
    endfunction

    always_comb
    begin
        diff_next.dx = sub33(s_tdata[3*IW +: IW], s_tdata[0*IW +: IW]);
        diff_next.dy = sub33(s_tdata[4*IW +: IW], s_tdata[1*IW +: IW]);
        diff_next.dz = sub33(s_tdata[5*IW +: IW], s_tdata[2*IW +: IW]);
        diff_next.ex = sub33(s_tdata[6*IW +: IW], s_tdata[0*IW +: IW]);
        diff_next.ey = sub33(s_tdata[7*IW +: IW], s_tdata[1*IW +: IW]);
        diff_next.ez = sub33(s_tdata[8*IW +: IW], s_tdata[2*IW +: IW]);
    end

    always_comb
    begin
        scale_next.dx   = diff_reg.dx;
        scale_next.dy   = diff_reg.dy;
        scale_next.ex   = diff_reg.ex;
        scale_next.ey   = diff_reg.ey;
        scale_next.gex  = gscale(diff_reg.ex, GAIN_Q29);
        scale_next.gey  = gscale(diff_reg.ey, GAIN_Q29);
        scale_next.gez  = gscale(diff_reg.ez, GAIN_Q29);
        scale_next.gdz  = gscale(-diff_reg.dz, GAIN_Q29);
        scale_next.gez2 = gscale(diff_reg.ez, GAIN2_Q29);
        scale_next.flat = (diff_reg.dx == '0) && (diff_reg.dy == '0);
        scale_next.zero = (diff_reg.dx == '0) && (diff_reg.dy == '0) && (diff_reg.dz == '0);
    end

    // heading chain: a flat segment skips rotation and carries the gain-scaled error
    always_comb
    begin
        p1_next[0].c = cordic_setup(widen16(scale_reg.dx), widen16(scale_reg.dy),
                                    scale_reg.flat ? scale_reg.gex : widen16(scale_reg.ex),
                                    scale_reg.flat ? scale_reg.gey : widen16(scale_reg.ey));
        p1_next[0].gdz  = scale_reg.gdz;
        p1_next[0].gez  = scale_reg.gez;
        p1_next[0].gez2 = scale_reg.gez2;
        p1_next[0].zero = scale_reg.zero;
    end

    // pitch chain: equal waypoints carry the squared-gain vertical error instead
    always_comb
    begin
        p2_next[0].c = cordic_setup(p1_reg[N].c.x, p1_reg[N].gdz, p1_reg[N].c.cx,
                                    p1_reg[N].zero ? -p1_reg[N].gez2 : -p1_reg[N].gez);
        p2_next[0].heading = p1_reg[N].c.ang;
        p2_next[0].yk      = p1_reg[N].c.cy;
    end

    always_comb
    begin
        p3_next[0].h       = cordic_setup(lah_reg, p2_reg[N].yk, '0, '0);
        p3_next[0].v       = cordic_setup(lav_reg, -p2_reg[N].c.cy, '0, '0);
        p3_next[0].heading = p2_reg[N].heading;
        p3_next[0].pitch   = p2_reg[N].c.ang;
    end

    for (genvar i = 1; i <= N; i++)
    begin : g_stage
        always_comb
        begin
            p1_next[i]   = p1_reg[i-1];
            p1_next[i].c = cordic_step(p1_reg[i-1].c, 5'(i-1));
            p2_next[i]   = p2_reg[i-1];
            p2_next[i].c = cordic_step(p2_reg[i-1].c, 5'(i-1));
            p3_next[i]   = p3_reg[i-1];
            p3_next[i].h = cordic_step(p3_reg[i-1].h, 5'(i-1));
            p3_next[i].v = cordic_step(p3_reg[i-1].v, 5'(i-1));
        end
    end

    always_comb
    begin
        m_tdata_next[OW-1:0] = to_out({p3_reg[N].heading[AW-1], p3_reg[N].heading}
                                      - {p3_reg[N].h.ang[AW-1], p3_reg[N].h.ang});
        m_tdata_next[2*OW-1:OW] = to_out({p3_reg[N].pitch[AW-1], p3_reg[N].pitch}
                                         + {p3_reg[N].v.ang[AW-1], p3_reg[N].v.ang});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_h_reg <= LOOKAHEAD_RESET;
            cfg_v_reg <= LOOKAHEAD_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_LOOKAHEAD_H: cfg_h_reg <= cfg_data;
                REG_LOOKAHEAD_V: cfg_v_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i <= N; i++)
            begin
                v_p1_reg[i] <= 1'b0;
                v_p2_reg[i] <= 1'b0;
                v_p3_reg[i] <= 1'b0;
            end
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
            if (adv)
            begin
                v1_reg      <= s_tvalid;
                v2_reg      <= v1_reg;
                v_p1_reg[0] <= v2_reg;
                v_p2_reg[0] <= v_p1_reg[N];
                v_p3_reg[0] <= v_p2_reg[N];
                for (int i = 1; i <= N; i++)
                begin
                    v_p1_reg[i] <= v_p1_reg[i-1];
                    v_p2_reg[i] <= v_p2_reg[i-1];
                    v_p3_reg[i] <= v_p3_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lah_reg <= gscale({2'b00, cfg_h_reg}, GAIN_Q29);
        lav_reg <= gscale({2'b00, cfg_v_reg}, GAIN2_Q29);
        if (adv)
        begin
            diff_reg  <= diff_next;
            scale_reg <= scale_next;
            for (int i = 0; i <= N; i++)
            begin
                p1_reg[i] <= p1_next[i];
                p2_reg[i] <= p2_next[i];
                p3_reg[i] <= p3_next[i];
            end
            if (v_p3_reg[N])
                m_tdata_reg <= m_tdata_next;
        end
    end

    `LGA_ASSERT_NOW(a_stall_cause, clk, rst_n, !s_tready,
        v_p3_reg[N] && m_tvalid_reg, "stall without a blocked result")
    `LGA_ASSERT_NEXT(a_result_load, clk, rst_n, v_p3_reg[N] && adv,
        m_tvalid_reg, "finished word not presented")
    `LGA_ASSERT_NOW(a_bypass_angle, clk, rst_n, v_p2_reg[N] && !p2_reg[N].c.act,
        p2_reg[N].c.ang == '0, "skipped pitch rotation produced an angle")
    `LGA_ASSERT_NEXT(a_cfg_write, clk, rst_n, cfg_wr_en && (cfg_index == REG_LOOKAHEAD_H),
        cfg_h_reg == $past(cfg_data), "lookahead write lost")

endmodule

[verif/tb_los_guidance_angles_unit.sv]
// Testbench for the line-of-sight guidance angle unit: directed and random words checked in order
module tb_los_guidance_angles_unit;
    import lga_pkg::*;

    localparam int SETTLE_CYCLES = 3 * STEPS_DEFAULT + 20;

    localparam longint ATAN_Q30 [16] = '{
        843314857, 497837829, 263043837, 133525159,
        67021687, 33543516, 16775851, 8388437,
        4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768
    };
    localparam longint PI_RAD_Q30 = 64'sd3373259426;
    localparam longint K1_Q29     = 64'sd884097682;
    localparam longint K2_Q29     = 64'sd1455896918;

    typedef struct {
        logic [OW-1:0] yaw;
        logic [OW-1:0] pitch;
    } angles_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [NUM_IN*IW-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [2*OW-1:0]      m_tdata;
    logic                 cfg_wr_en;
    logic                 cfg_index;
    logic [CW-1:0]        cfg_data;

    longint  look_h;
    longint  look_v;
    angles_t angle_queue[$];
    int      fail_count;
    bit      send_no_gaps;
    bit      recv_no_stall;
    int      recv_hold_cycles;

    los_guidance_angles_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint scale_gain(longint v, longint c);
        return (v * c) >>> 13;
    endfunction

    function automatic longint cordic_angle(inout longint x, inout longint y,
                                            inout longint cx, inout longint cy);
        longint ang;
        longint xs, ys, cxs, cys;
        ang = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            ang = (y >= 0) ? PI_RAD_Q30 : -PI_RAD_Q30;
            x = -x; y = -y; cx = -cx; cy = -cy;
        end
        for (int i = 0; i < STEPS_DEFAULT; i++)
        begin
            xs = x >>> i; ys = y >>> i; cxs = cx >>> i; cys = cy >>> i;
            if (y >= 0)
            begin
                x += ys; y -= xs; cx += cys; cy -= cxs; ang += ATAN_Q30[i];
            end
            else
            begin
                x -= ys; y += xs; cx -= cys; cy += cxs; ang -= ATAN_Q30[i];
            end
        end
        return ang;
    endfunction

    function automatic logic [OW-1:0] angle_word(longint a);
        longint r;
        r = (a + 131072) >>> 18;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[OW-1:0];
    endfunction

    function automatic longint coord(logic [NUM_IN*IW-1:0] d, int n);
        return longint'($signed(d[n*IW +: IW]));
    endfunction

    function automatic angles_t guidance_angles(logic [NUM_IN*IW-1:0] d);
        longint px, py, pz, dx, dy, dz, ex, ey, ez;
        longint heading, climb, hk, xk, yk, zk2, a, b, z1, z2, ah, av;
        longint vx, vy, cx, cz;
        angles_t r;
        px = coord(d, 0); py = coord(d, 1); pz = coord(d, 2);
        dx = coord(d, 3) - px; dy = coord(d, 4) - py; dz = coord(d, 5) - pz;
        ex = coord(d, 6) - px; ey = coord(d, 7) - py; ez = coord(d, 8) - pz;
        if (dx == 0 && dy == 0)
        begin
            heading = 0;
            hk = 0;
            xk = scale_gain(ex, K1_Q29);
            yk = scale_gain(ey, K1_Q29);
        end
        else
        begin
            a = dx * 65536; b = dy * 65536;
            xk = ex * 65536; yk = ey * 65536;
            heading = cordic_angle(a, b, xk, yk);
            hk = a;
        end
        if (dx == 0 && dy == 0 && dz == 0)
        begin
            climb = 0;
            zk2 = scale_gain(ez, K2_Q29);
        end
        else
        begin
            vx = hk; vy = scale_gain(-dz, K1_Q29);
            cx = xk; cz = -scale_gain(ez, K1_Q29);
            climb = cordic_angle(vx, vy, cx, cz);
            zk2 = -cz;
        end
        a = scale_gain(look_h, K1_Q29); b = yk; z1 = 0; z2 = 0;
        ah = cordic_angle(a, b, z1, z2);
        a = scale_gain(look_v, K2_Q29); b = zk2; z1 = 0; z2 = 0;
        av = cordic_angle(a, b, z1, z2);
        r.yaw = angle_word(heading - ah);
        r.pitch = angle_word(climb + av);
        return r;
    endfunction

    // predict on input handshake, check on output handshake
    always @(posedge clk)
    begin
        angles_t exp_a;
        if (rst_n && s_tvalid && s_tready)
            angle_queue.push_back(guidance_angles(s_tdata));
        if (rst_n && m_tvalid && m_tready)
        begin
            if (angle_queue.size() == 0)
            begin
                $error("unexpected word: yaw %0d pitch %0d",
                       $signed(m_tdata[OW-1:0]), $signed(m_tdata[2*OW-1:OW]));
                fail_count++;
            end
            else
            begin
                exp_a = angle_queue.pop_front();
                if (m_tdata[OW-1:0] !== exp_a.yaw)
                begin
                    $error("yaw_cmd: expected %0d, actual %0d",
                           $signed(exp_a.yaw), $signed(m_tdata[OW-1:0]));
                    fail_count++;
                end
                if (m_tdata[2*OW-1:OW] !== exp_a.pitch)
                begin
                    $error("pitch_cmd: expected %0d, actual %0d",
                           $signed(exp_a.pitch), $signed(m_tdata[2*OW-1:OW]));
                    fail_count++;
                end
            end
        end
    end

    // receiver: random stalls, optional long hold-off
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (recv_hold_cycles > 0)
            begin
                gap = recv_hold_cycles;
                recv_hold_cycles = 0;
            end
            else if (recv_no_stall)
                gap = 0;
            else
                gap = $urandom_range(0, 10);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    task automatic send_word(logic [NUM_IN*IW-1:0] d);
        int gap;
        gap = send_no_gaps ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_points(int px, int py, int pz, int nx, int ny, int nz,
                               int qx, int qy, int qz);
        send_word({qz, qy, qx, nz, ny, nx, pz, py, px});
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (angle_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [CW-1:0] val);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_LOOKAHEAD_H)
            look_h = val;
        else
            look_v = val;
    endtask

    function automatic int rand_coord(int base);
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return base + $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            2: return base + $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
            default: return base;
        endcase
    endfunction

    task automatic send_random(int n);
        int px, py, pz, nx, ny, nz;
        for (int i = 0; i < n; i++)
        begin
            px = $urandom; py = $urandom; pz = $urandom;
            if ($urandom_range(0, 3) == 0)
            begin
                px = $signed(px) >>> 8; py = $signed(py) >>> 8; pz = $signed(pz) >>> 8;
            end
            nx = rand_coord(px); ny = rand_coord(py); nz = rand_coord(pz);
            send_points(px, py, pz, nx, ny, nz,
                        rand_coord(px), rand_coord(py), rand_coord(pz));
        end
    endtask

    task automatic test_directed_geometry();
        int mn;
        int mx;
        mn = 32'sh8000_0000;
        mx = 32'sh7FFF_FFFF;
        // equal waypoints, vehicle on and off the point
        send_points(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_points(65536, 65536, 65536, 65536, 65536, 65536, 131072, -65536, 655360);
        send_points(5, 5, 5, 5, 5, 5, 5, 5, -655360);
        // equal horizontal waypoints, vertical segment
        send_points(0, 0, 0, 0, 0, 655360, 65536, 65536, 65536);
        send_points(0, 0, 0, 0, 0, -655360, -65536, 0, 0);
        // all four quadrants and the axes
        send_points(0, 0, 0, 655360, 655360, 0, 0, 65536, 0);
        send_points(0, 0, 0, -655360, 655360, 0, 0, 65536, 0);
        send_points(0, 0, 0, -655360, -655360, 0, 0, -65536, 0);
        send_points(0, 0, 0, 655360, -655360, 0, 65536, 0, 65536);
        send_points(0, 0, 0, -655360, 0, 0, 0, 0, 0);
        send_points(0, 0, 0, 0, 655360, 65536, 0, 0, 0);
        // field extremes
        send_points(mn, mn, mn, mx, mx, mx, mn, mx, mn);
        send_points(mx, mx, mx, mn, mn, mn, mx, mn, mx);
        send_points(mx, mn, mx, mn, mx, mn, mn, mn, mn);
        send_points(mn, mx, mn, mx, mn, mx, mx, mx, mx);
        send_points(-1, -1, -1, -1, -1, -1, mn, mx, 0);
        send_points(0, 0, 0, 1, 0, 0, 0, 1, -1);
        send_points(0, 0, 0, mx, 0, 0, 0, mx, mn);
        // vehicle far off the path, saturating angle terms
        send_points(0, 0, 0, 655360, 0, 0, 0, mx, mn);
        send_points(0, 0, 0, 655360, 0, 0, 0, mn, mx);
    endtask

    task automatic test_lookahead_settings();
        write_reg(REG_LOOKAHEAD_H, 31'd1);
        write_reg(REG_LOOKAHEAD_V, 31'h7FFF_FFFF);
        send_random(120);
        write_reg(REG_LOOKAHEAD_H, 31'h7FFF_FFFF);
        write_reg(REG_LOOKAHEAD_V, 31'd1);
        send_random(120);
        // zero lookahead: atan term pinned at a quarter turn, or zero with no cross error
        write_reg(REG_LOOKAHEAD_H, 31'd0);
        write_reg(REG_LOOKAHEAD_V, 31'd0);
        send_points(0, 0, 0, 655360, 0, 0, 0, 0, 0);
        send_points(0, 0, 0, 655360, 0, 0, 0, 65536, -65536);
        send_points(0, 0, 0, 655360, 0, 0, 0, -65536, 65536);
        send_random(60);
        write_reg(REG_LOOKAHEAD_H, CW'($urandom));
        write_reg(REG_LOOKAHEAD_V, CW'($urandom_range(1, 32'h000F_FFFF)));
        send_random(150);
    endtask

    task automatic test_backpressure();
        drain();
        send_no_gaps = 1'b1;
        recv_hold_cycles = 400;
        send_random(200);
        send_no_gaps = 1'b0;
    endtask

    task automatic test_streaming();
        send_no_gaps = 1'b1;
        recv_no_stall = 1'b1;
        send_random(200);
        send_no_gaps = 1'b0;
        recv_no_stall = 1'b0;
        send_random(200);
    endtask

    task automatic test_random();
        write_reg(REG_LOOKAHEAD_H, LOOKAHEAD_RESET);
        write_reg(REG_LOOKAHEAD_V, LOOKAHEAD_RESET);
        send_random(580);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_LOOKAHEAD_H;
        cfg_data = '0;
        look_h = LOOKAHEAD_RESET;
        look_v = LOOKAHEAD_RESET;
        fail_count = 0;
        send_no_gaps = 1'b0;
        recv_no_stall = 1'b0;
        recv_hold_cycles = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_geometry();
        test_lookahead_settings();
        test_backpressure();
        test_streaming();
        test_random();
        drain();
        if (fail_count == 0 && angle_queue.size() == 0)
            $display("los_guidance_angles_unit: match");
        else
            $display("los_guidance_angles_unit: mismatch");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("los_guidance_angles_unit: mismatch");
        $finish;
    end

endmodule
